[hw/rtl/pcm_voice_mixer_saturating_defines.svh]
// Assertion macros shared by the mixer RTL; the asserting module provides clk and arst_n.
`ifndef PCM_VOICE_MIXER_SATURATING_DEFINES_SVH
`define PCM_VOICE_MIXER_SATURATING_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define PVMS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define PVMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/pvms_pkg.sv]
// Types and constants shared by the PCM voice mixer modules.
`default_nettype none

package pvms_pkg;

	localparam int LEN_W = 15;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 1;

	typedef enum logic [1:0] {
		OP_WRITE_SAMPLE = 2'd0,
		OP_SET_INFO     = 2'd1,
		OP_PLAY         = 2'd2,
		OP_MIX          = 2'd3
	} op_e;

	localparam logic [CFG_INDEX_W-1:0] REG_SOUND_ENABLE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MUSIC_ENABLE = 1'd1;

	typedef struct packed {
		logic [1:0]         op;
		logic [2:0]         voice;
		logic [13:0]        word_address;
		logic signed [15:0] sample_value;
		logic [14:0]        frame_count;
		logic [1:0]         channel_count;
		logic signed [15:0] music_left;
		logic signed [15:0] music_right;
		logic               music_present;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] mix_left;
		logic signed [15:0] mix_right;
		logic [7:0]         voices_playing;
	} out_item_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic write_word;
		logic set_info;
		logic play;
		logic seed;
		logic read_left;
		logic read_right;
		logic add_left;
		logic add_right;
		logic step_voice;
		logic stop_voice;
		logic next_voice;
	} cmd_t;

	// Status of the voice under the scan pointer.
	typedef struct packed {
		logic sound_en;
		logic ready;
		logic active;
		logic last;
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/pvms_ctrl.sv]
// Sequencer for the mixer: accepts commands and steps the voice scan of a mix frame.
`default_nettype none

`include "pcm_voice_mixer_saturating_defines.svh"

module pvms_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        op,
	input  wire pvms_pkg::status_t status,
	output pvms_pkg::cmd_t         cmd,
	output logic                   busy,
	output logic                   done
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_VOICE  = 4'b0010,
		ST_WORD_R = 4'b0100,
		ST_WORD_A = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (op)
						pvms_pkg::OP_WRITE_SAMPLE: cmd.write_word = 1'b1;
						pvms_pkg::OP_SET_INFO:     cmd.set_info = 1'b1;
						pvms_pkg::OP_PLAY:         cmd.play = 1'b1;
						pvms_pkg::OP_MIX: begin
							cmd.seed = 1'b1;
							state_d  = ST_VOICE;
						end
					endcase
				end
			end
			ST_VOICE: begin
				if (!status.sound_en) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else if (status.ready) begin
					cmd.read_left = 1'b1;
					state_d       = ST_WORD_R;
				end else begin
					// idle or expired voice: drop it without a contribution
					cmd.stop_voice = status.active;
					if (status.last) begin
						done_d  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.next_voice = 1'b1;
					end
				end
			end
			ST_WORD_R: begin
				cmd.read_right = 1'b1;
				cmd.add_left   = 1'b1;
				state_d        = ST_WORD_A;
			end
			ST_WORD_A: begin
				cmd.add_right  = 1'b1;
				cmd.step_voice = 1'b1;
				if (status.last) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.next_voice = 1'b1;
					state_d        = ST_VOICE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	`PVMS_ASSERT_SAME(a_done_when_idle, done_q, state_q == ST_IDLE, "result beat while scanning")
	`PVMS_ASSERT_NEXT(a_mix_enters_scan, start && (state_q == ST_IDLE) && (op == pvms_pkg::OP_MIX), state_q == ST_VOICE, "mix command did not start the scan")
	`PVMS_ASSERT_NEXT(a_right_then_add, state_q == ST_WORD_R, state_q == ST_WORD_A, "right read not followed by accumulate")
	`PVMS_ASSERT_SAME(a_add_after_right, state_q == ST_WORD_A, $past(state_q) == ST_WORD_R, "accumulate without a preceding read")

endmodule

`default_nettype wire

[hw/rtl/pvms_datapath.sv]
// Mixer datapath: sample store, voice state, configuration and saturating accumulators.
`default_nettype none

module pvms_datapath #(
	parameter int VOICE_COUNT     = 8,
	parameter int WORDS_PER_VOICE = 16384
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pvms_pkg::in_item_t                  request,
	input  wire pvms_pkg::cmd_t                      cmd,
	input  wire logic                                cfg_write,
	input  wire logic [pvms_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [pvms_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pvms_pkg::status_t                        status,
	output pvms_pkg::out_item_t                      result
);

	localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int AW = $clog2(WORDS_PER_VOICE);
	localparam int OW = (AW > 16) ? AW : 16;
	localparam int DEPTH = VOICE_COUNT * WORDS_PER_VOICE;
	localparam int MW = $clog2(DEPTH);
	localparam int LW = pvms_pkg::LEN_W;

	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [16:0] s;
		s = 17'(a) + 17'(b);
		if (s > 17'sd32767) begin
			return 16'sh7FFF;
		end else if (s < -17'sd32768) begin
			return 16'sh8000;
		end
		return s[15:0];
	endfunction

	logic [15:0]             store_q [DEPTH];
	logic signed [15:0]      rdata_q;
	logic [LW-1:0]           length_q [VOICE_COUNT];
	logic [LW-1:0]           position_q [VOICE_COUNT];
	logic [VOICE_COUNT-1:0]  stereo_q;
	logic [VOICE_COUNT-1:0]  loaded_q;
	logic [VOICE_COUNT-1:0]  active_q;
	logic [VW-1:0]           idx_q;
	logic signed [15:0]      acc_l_q;
	logic signed [15:0]      acc_r_q;
	logic                    sound_q;
	logic                    music_q;

	// request decode
	logic          req_hit;
	logic          addr_ok;
	logic [VW-1:0] req_idx;
	logic          req_stereo;
	logic [LW-1:0] req_len;
	logic [MW-1:0] waddr;

	always_comb begin
		req_hit    = (32'(request.voice) < VOICE_COUNT);
		addr_ok    = (32'(request.word_address) < WORDS_PER_VOICE);
		req_idx    = VW'(request.voice);
		req_stereo = request.channel_count[1];
		req_len    = request.frame_count;
		if (req_stereo) begin
			if (32'(request.frame_count) > 32'(WORDS_PER_VOICE / 2)) begin
				req_len = LW'(WORDS_PER_VOICE / 2);
			end
		end else if (32'(request.frame_count) > 32'(WORDS_PER_VOICE)) begin
			req_len = LW'(WORDS_PER_VOICE);
		end
		waddr = MW'(req_idx) * MW'(WORDS_PER_VOICE) + MW'(request.word_address);
	end

	// scan voice view
	logic [LW-1:0] cur_pos;
	logic [LW-1:0] cur_len;
	logic [LW-1:0] pos_inc;
	logic          cur_stereo;
	logic [OW-1:0] ofs;
	logic [MW-1:0] raddr;

	always_comb begin
		cur_pos    = position_q[idx_q];
		cur_len    = length_q[idx_q];
		cur_stereo = stereo_q[idx_q];
		pos_inc    = cur_pos + LW'(1);
		if (cur_stereo) begin
			ofs = OW'({cur_pos, cmd.read_right});
		end else begin
			ofs = OW'(cur_pos);
		end
		raddr = MW'(idx_q) * MW'(WORDS_PER_VOICE) + MW'(ofs);
	end

	assign status.sound_en = sound_q;
	assign status.active   = active_q[idx_q];
	assign status.ready    = active_q[idx_q] && (cur_pos < cur_len);
	assign status.last     = (32'(idx_q) == 32'(VOICE_COUNT - 1));

	// sample store: one write or one read per cycle, read data registered
	always_ff @(posedge clk) begin
		if (cmd.write_word && req_hit && addr_ok) begin
			store_q[waddr] <= request.sample_value;
		end
		if (cmd.read_left || cmd.read_right) begin
			rdata_q <= store_q[raddr];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_q <= 1'b1;
			music_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pvms_pkg::REG_SOUND_ENABLE: sound_q <= cfg_data[0];
				pvms_pkg::REG_MUSIC_ENABLE: music_q <= cfg_data[0];
			endcase
		end
	end

	// voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICE_COUNT; v++) begin
				length_q[v]   <= '0;
				position_q[v] <= '0;
			end
			stereo_q <= '0;
			loaded_q <= '0;
			active_q <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.set_info && req_hit) begin
				length_q[req_idx]   <= req_len;
				stereo_q[req_idx]   <= req_stereo;
				loaded_q[req_idx]   <= 1'b1;
				active_q[req_idx]   <= 1'b0;
				position_q[req_idx] <= '0;
			end
			if (cmd.play && req_hit && loaded_q[req_idx]) begin
				position_q[req_idx] <= '0;
				active_q[req_idx]   <= 1'b1;
			end
			if (cmd.stop_voice) begin
				active_q[idx_q] <= 1'b0;
			end
			if (cmd.step_voice) begin
				position_q[idx_q] <= pos_inc;
				if (pos_inc >= cur_len) begin
					active_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.seed) begin
				idx_q <= '0;
			end else if (cmd.next_voice) begin
				idx_q <= idx_q + VW'(1);
			end
		end
	end

	// accumulators
	always_ff @(posedge clk) begin
		if (cmd.seed) begin
			if (music_q && request.music_present) begin
				acc_l_q <= request.music_left;
				acc_r_q <= request.music_right;
			end else begin
				acc_l_q <= '0;
				acc_r_q <= '0;
			end
		end else begin
			if (cmd.add_left) begin
				acc_l_q <= sat_add(acc_l_q, rdata_q);
				if (!cur_stereo) begin
					acc_r_q <= sat_add(acc_r_q, rdata_q);
				end
			end
			if (cmd.add_right && cur_stereo) begin
				acc_r_q <= sat_add(acc_r_q, rdata_q);
			end
		end
	end

	assign result.mix_left  = acc_l_q;
	assign result.mix_right = acc_r_q;

	for (genvar g = 0; g < 8; g++) begin : g_play
		if (g < VOICE_COUNT) begin : g_on
			assign result.voices_playing[g] = active_q[g];
		end else begin : g_off
			assign result.voices_playing[g] = 1'b0;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/pcm_voice_mixer_saturating.sv]
// Top level of the eight-voice PCM16 sample mixer with saturating stereo output.
//
//  channel   | handshake                  | beat
//  ----------+----------------------------+-------------------------------
//  request   | start high, busy low       | in_item_t: op, voice, data
//  result    | result_valid, one cycle    | out_item_t: mix, voices bits
//  config    | cfg_write                  | cfg_index, cfg_data
//
// Write-sample, set-info and play commands complete at the accepting edge; busy stays low.
// A mix command scans the voices one after another, skipping idle or expired voices; a
// playing voice gets a left read, a right read with the left accumulate, then the right
// accumulate, paced by the single-port sample store and its registered read. The result
// beat follows the last scan step in the next cycle; with sound off, no voice is read.
// Reset restores both enables, unloads and stops every voice; the store keeps old data.
// The receiver cannot stall: take the result in the cycle result_valid is high.
`default_nettype none

module pcm_voice_mixer_saturating #(
	parameter int VOICE_COUNT     = 8,
	parameter int WORDS_PER_VOICE = 16384
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire pvms_pkg::in_item_t               request,
	output logic                                  result_valid,
	output pvms_pkg::out_item_t                   result,
	input  wire logic                             cfg_write,
	input  wire logic [pvms_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [pvms_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pvms_pkg::cmd_t    cmd;
	pvms_pkg::status_t status;

	// sequencer: decode commands, step the voice scan
	pvms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (request.op),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (result_valid)
	);

	// datapath: store, voice table, accumulators; result fields come straight from registers
	pvms_datapath #(
		.VOICE_COUNT     (VOICE_COUNT),
		.WORDS_PER_VOICE (WORDS_PER_VOICE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cmd       (cmd),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.result    (result)
	);

endmodule

`default_nettype wire
